FILE: hw/rtl/gpe_pkg.sv
`default_nettype none
package gpe_pkg;

  localparam int DISP_W = 240;
  localparam int DISP_H = 320;

  localparam int NUM_COLS = 16;
  localparam int COL_W    = 4;

  localparam logic [7:0] REG_FONT_WIDTH = 8'd0;
  localparam logic [7:0] REG_TEXT_COLOR = 8'd1;
  localparam logic [7:0] REG_FRAME_BASE = 8'd2;

  localparam logic [4:0]  FONT_WIDTH_RST = 5'd16;
  localparam logic [23:0] TEXT_COLOR_RST = 24'h00ffff;
  localparam logic [31:0] FRAME_BASE_RST = 32'h0;

  // one classified glyph row waiting for the pixel sequencer
  typedef struct packed {
    logic [NUM_COLS-1:0] mask;
    logic [15:0]         ox;
    logic                y_ok;
    logic [31:0]         base;
  } gpe_entry_t;

endpackage
`default_nettype wire

FILE: hw/rtl/gpe_front.sv
`default_nettype none
module gpe_front (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [15:0]       in_row_bits,
  input  wire logic [5:0]        in_row_number,
  input  wire logic [15:0]       in_origin_x,
  input  wire logic [15:0]       in_origin_y,
  input  wire logic [4:0]        font_width,
  input  wire logic [31:0]       frame_base,
  input  wire logic              q_full,
  output logic                   q_push,
  output gpe_pkg::gpe_entry_t    q_entry
);
  import gpe_pkg::*;

  logic [NUM_COLS-1:0] mask;
  logic [16:0]         y_sum;
  logic [31:0]         lin;

  // column hit mask, bit c is glyph column c
  always_comb begin
    logic hit;
    mask = '0;
    for (int c = 0; c < NUM_COLS; c++) begin
      hit = 1'b0;
      if (font_width <= 5'd12) begin
        if (font_width == 5'd12) begin
          hit = in_row_bits[COL_W'(15 - c)];
        end else begin
          hit = (c <= 7) && in_row_bits[COL_W'(7 - c)];
        end
      end else begin
        hit = in_row_bits[COL_W'(c)];
      end
      mask[c] = hit && (5'(c) < font_width);
    end
  end

  assign y_sum = {1'b0, in_origin_y} + 17'(in_row_number);
  assign lin   = 32'(y_sum) * 32'(DISP_W) + 32'(in_origin_x);

  assign in_stall      = q_full;
  assign q_push        = in_valid && !q_full && (mask != '0);
  assign q_entry.mask  = mask;
  assign q_entry.ox    = in_origin_x;
  assign q_entry.y_ok  = y_sum < 17'(DISP_H);
  assign q_entry.base  = frame_base + lin + {lin[30:0], 1'b0};

endmodule
`default_nettype wire

FILE: hw/rtl/gpe_queue.sv
`default_nettype none
module gpe_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire gpe_pkg::gpe_entry_t push_entry,
  output logic                     full,
  input  wire logic                pop,
  output logic                     head_valid,
  output gpe_pkg::gpe_entry_t      head_entry
);
  import gpe_pkg::*;

  gpe_entry_t  mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign full       = count_r == 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/gpe_back.sv
`default_nettype none
module gpe_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                head_valid,
  input  wire gpe_pkg::gpe_entry_t head_entry,
  output logic                     pop,
  input  wire logic [23:0]         text_color,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [31:0]              out_pixel_address,
  output logic [23:0]              out_pixel_color,
  output logic                     out_off_screen,
  output logic                     out_last_of_row
);
  import gpe_pkg::*;

  logic                busy_r, busy_nxt;
  logic [NUM_COLS-1:0] mask_r, mask_nxt;
  logic [15:0]         ox_r;
  logic                y_ok_r;
  logic [31:0]         base_r;

  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         addr_r;
  logic [23:0]         color_r;
  logic                off_r;
  logic                last_r;

  logic [COL_W-1:0]    col;
  logic [NUM_COLS-1:0] rest;
  logic [16:0]         x_sum;
  logic                on_scr;
  logic                emit;
  logic                load;

  // lowest remaining column
  always_comb begin
    col = '0;
    for (int i = NUM_COLS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        col = COL_W'(i);
      end
    end
  end

  assign rest   = mask_r & ~(NUM_COLS'(1) << col);
  assign x_sum  = {1'b0, ox_r} + 17'(col);
  assign on_scr = y_ok_r && (x_sum < 17'(DISP_W));
  assign emit   = busy_r && (!out_valid_r || !out_stall);
  assign load   = head_valid && (!busy_r || (emit && rest == '0));
  assign pop    = load;

  always_comb begin
    busy_nxt      = busy_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      mask_nxt      = rest;
      busy_nxt      = rest != '0;
      out_valid_nxt = 1'b1;
    end
    if (load) begin
      mask_nxt = head_entry.mask;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    if (load) begin
      ox_r   <= head_entry.ox;
      y_ok_r <= head_entry.y_ok;
      base_r <= head_entry.base;
    end
    if (emit) begin
      addr_r  <= on_scr ? base_r + 32'({col, 1'b0}) + 32'(col) : 32'h0;
      color_r <= text_color;
      off_r   <= !on_scr;
      last_r  <= rest == '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_address = addr_r;
  assign out_pixel_color   = color_r;
  assign out_off_screen    = off_r;
  assign out_last_of_row   = last_r;

endmodule
`default_nettype wire

FILE: hw/rtl/glyph_row_pixel_expander_unit.sv
`default_nettype none
// Expands one glyph row word into frame-buffer pixel writes, one output word per set
// glyph column in column order, with last_of_row on the final one and no output for a
// row with no set column. The pixel sequencer sends one set column at a time (at most
// 16 per row), may be held by out_stall, and takes the next row with the last pixel;
// the front classifies a row combinationally and a two-entry queue lets it take rows
// ahead while pixels are still going out. Off-screen pixels come out flagged with
// address zero. Configuration registers: 0 font width, 1 text color, 2 frame base;
// cfg_ready is always high and a write is registered before it is used.
module glyph_row_pixel_expander_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_row_bits,
  input  wire logic [5:0]  in_row_number,
  input  wire logic [15:0] in_origin_x,
  input  wire logic [15:0] in_origin_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_pixel_address,
  output logic [23:0]      out_pixel_color,
  output logic             out_off_screen,
  output logic             out_last_of_row,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import gpe_pkg::*;

  logic [4:0]  font_width_r;
  logic [23:0] text_color_r;
  logic [31:0] frame_base_r;

  logic        q_full;
  logic        q_push;
  gpe_entry_t  q_entry;
  logic        q_pop;
  logic        head_valid;
  gpe_entry_t  head_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_width_r <= FONT_WIDTH_RST;
      text_color_r <= TEXT_COLOR_RST;
      frame_base_r <= FRAME_BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FONT_WIDTH: font_width_r <= cfg_data[4:0];
        REG_TEXT_COLOR: text_color_r <= cfg_data[23:0];
        REG_FRAME_BASE: frame_base_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gpe_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_row_bits   (in_row_bits),
    .in_row_number (in_row_number),
    .in_origin_x   (in_origin_x),
    .in_origin_y   (in_origin_y),
    .font_width    (font_width_r),
    .frame_base    (frame_base_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  gpe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  gpe_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_entry        (head_entry),
    .pop               (q_pop),
    .text_color        (text_color_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .out_off_screen    (out_off_screen),
    .out_last_of_row   (out_last_of_row)
  );

endmodule
`default_nettype wire
